// File: rtl/core/dsd_pkg.sv
package dsd_pkg;

    // operand forms of the shared compare-subtract unit
    typedef enum logic [1:0] {
        CS_DIV,     // radix-2 step: remainder shifted left, next dividend bit in
        CS_DIGIT,   // digit step: remainder against divisor shifted left
        CS_ROUND    // rounding: twice the remainder against divisor
    } t_cs_op;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_DIV_ZERO = 2'd1;
    localparam t_status ST_TOO_BIG  = 2'd2;
    localparam t_status ST_OVF      = 2'd3;

endpackage

// File: rtl/core/dsd_cmp_sub.sv
module dsd_cmp_sub #(
    parameter int WORD_BITS = 32
) (
    input  dsd_pkg::t_cs_op        i_op,
    input  logic [WORD_BITS-1:0]   i_rem,
    input  logic                   i_qmsb,
    input  logic [WORD_BITS-1:0]   i_mb,
    input  logic [1:0]             i_shift,
    output logic                   o_ge,
    output logic [WORD_BITS-1:0]   o_next
);
    import dsd_pkg::*;

    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;

    always_comb begin
        unique case (i_op)
            CS_DIV: begin
                a = {i_rem[WORD_BITS-2:0], i_qmsb};
                b = i_mb;
            end
            CS_DIGIT: begin
                a = i_rem;
                b = i_mb << i_shift;
            end
            CS_ROUND: begin
                a = {i_rem[WORD_BITS-2:0], 1'b0};
                b = i_mb;
            end
            default: begin
                a = i_rem;
                b = i_mb;
            end
        endcase
    end

    // one wide subtract serves compare and restore
    assign o_ge   = (a >= b);
    assign o_next = o_ge ? (a - b) : a;

endmodule

// File: rtl/core/dsd_mul10.sv
module dsd_mul10 #(
    parameter int WORD_BITS = 32
) (
    input  logic [WORD_BITS-1:0] i_x,
    output logic [WORD_BITS-1:0] o_x10
);
    // x*8 + x*2; caller keeps x small enough that the product fits
    assign o_x10 = (i_x << 3) + (i_x << 1);

endmodule

// File: rtl/core/decimal_scaled_divider_unit.sv
// Decimal scaled divider: round(|dividend| * 10^frac_digits / |divisor|)
// with the combined sign, as a fixed-point decimal result.
//
// Input channel (i_in_valid / o_in_ready): one beat carries dividend, divisor
// and frac_digits. Output channel (o_out_valid / i_out_ready): one beat per
// input beat with quotient and status (ok, divide by zero, divisor too big,
// overflow saturated to +/-(2^(WORD_BITS-1)-1)).
//
// One item at a time. The quotient is built by WORD_BITS radix-2 steps on a
// shared compare-subtract unit, then each fraction digit is made of one
// times-ten on the shared shift-add unit and four compare-subtract steps,
// then a rounding step and a hand-over step follow. A zero or oversized
// divisor goes straight from accept to the hand-over step. Overflow ends
// the digit loop early. The sustained rate is set by this one-unit iteration.
//
// The result sits in an output register, so a stalled receiver does not
// hold back the next accept; the block only waits in its final state while
// an earlier result is still untaken. Reset clears the sequencer and the
// output valid; no result is pending afterwards.
module decimal_scaled_divider_unit #(
    parameter int WORD_BITS       = 32,
    parameter int MAX_FRAC_DIGITS = 15
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [WORD_BITS-1:0] i_dividend,
    input  logic signed [WORD_BITS-1:0] i_divisor,
    input  logic [3:0]                  i_frac_digits,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [WORD_BITS-1:0] o_quotient,
    output dsd_pkg::t_status            o_status
);
    import dsd_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam logic [WORD_BITS-1:0] MAG_MAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] BIG_LIMIT = MAG_MAX / 10;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_DIGIT = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // sequencer and datapath registers
    logic [2:0]           r_state,  n_state;
    logic [WORD_BITS-1:0] r_q,      n_q;      // dividend bits shift out, quotient in
    logic [WORD_BITS-1:0] r_r,      n_r;      // partial remainder
    logic [WORD_BITS-1:0] r_mb,     n_mb;     // divisor magnitude
    logic                 r_neg,    n_neg;
    logic                 r_ovf,    n_ovf;
    t_status              r_status, n_status;
    logic [CNT_W-1:0]     r_cnt,    n_cnt;    // radix-2 step count
    logic [3:0]           r_digits, n_digits; // fraction digits still to make
    logic [2:0]           r_step,   n_step;   // 0: times ten, 1..4: digit bits
    logic [2:0]           r_d,      n_d;      // upper digit bits so far

    // output register
    logic                 r_o_valid,  n_o_valid;
    logic [WORD_BITS-1:0] r_o_quot,   n_o_quot;
    t_status              r_o_status, n_o_status;

    // accept-side decode
    logic [WORD_BITS-1:0] a_u, b_u, ma, mb;
    logic [3:0]           digits_clamped;

    // shared units
    t_cs_op               cs_op;
    logic [1:0]           cs_shift;
    logic                 cs_ge;
    logic [WORD_BITS-1:0] cs_next;
    logic [WORD_BITS-1:0] m10_in, m10_out;

    // digit and hand-over helpers
    logic [3:0]           digit;
    logic [WORD_BITS-1:0] q_digit;
    logic [WORD_BITS-1:0] q_inc;
    logic [WORD_BITS-1:0] q_div;
    logic [WORD_BITS-1:0] res_mag;
    logic [WORD_BITS-1:0] res;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_quotient  = signed'(r_o_quot);
    assign o_status    = r_o_status;

    assign a_u = i_dividend;
    assign b_u = i_divisor;
    assign ma  = a_u[WORD_BITS-1] ? (~a_u + 1'b1) : a_u;
    assign mb  = b_u[WORD_BITS-1] ? (~b_u + 1'b1) : b_u;
    assign digits_clamped = (32'(i_frac_digits) > MAX_FRAC_DIGITS)
                          ? 4'(MAX_FRAC_DIGITS) : i_frac_digits;

    always_comb begin
        unique case (r_state)
            S_DIV:   cs_op = CS_DIV;
            S_DIGIT: cs_op = CS_DIGIT;
            default: cs_op = CS_ROUND;
        endcase
    end

    // digit steps 1..4 test divisor shifted by 3..0
    assign cs_shift = 2'(3'd4 - r_step);

    dsd_cmp_sub #(
        .WORD_BITS (WORD_BITS)
    ) u_cmp_sub (
        .i_op    (cs_op),
        .i_rem   (r_r),
        .i_qmsb  (r_q[WORD_BITS-1]),
        .i_mb    (r_mb),
        .i_shift (cs_shift),
        .o_ge    (cs_ge),
        .o_next  (cs_next)
    );

    // times ten: remainder at step 0, quotient at the last digit step
    assign m10_in = (r_step == 3'd0) ? r_r : r_q;

    dsd_mul10 #(
        .WORD_BITS (WORD_BITS)
    ) u_mul10 (
        .i_x   (m10_in),
        .o_x10 (m10_out)
    );

    assign digit   = {r_d, cs_ge};
    assign q_digit = m10_out + {{(WORD_BITS-4){1'b0}}, digit};
    assign q_inc   = r_q + 1'b1;
    assign q_div   = {r_q[WORD_BITS-2:0], cs_ge};
    assign res_mag = r_ovf ? MAG_MAX : r_q;
    assign res     = r_neg ? (~res_mag + 1'b1) : res_mag;

    always_comb begin
        n_state    = r_state;
        n_q        = r_q;
        n_r        = r_r;
        n_mb       = r_mb;
        n_neg      = r_neg;
        n_ovf      = r_ovf;
        n_status   = r_status;
        n_cnt      = r_cnt;
        n_digits   = r_digits;
        n_step     = r_step;
        n_d        = r_d;
        n_o_valid  = r_o_valid;
        n_o_quot   = r_o_quot;
        n_o_status = r_o_status;

        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_neg    = a_u[WORD_BITS-1] ^ b_u[WORD_BITS-1];
                    n_ovf    = 1'b0;
                    n_mb     = mb;
                    n_r      = '0;
                    n_cnt    = '0;
                    n_step   = 3'd0;
                    n_d      = 3'd0;
                    n_digits = digits_clamped;
                    if (mb == '0) begin
                        n_q      = '0;
                        n_neg    = 1'b0;
                        n_status = ST_DIV_ZERO;
                        n_state  = S_DONE;
                    end else if (mb >= BIG_LIMIT) begin
                        n_q      = '0;
                        n_neg    = 1'b0;
                        n_status = ST_TOO_BIG;
                        n_state  = S_DONE;
                    end else begin
                        n_q      = ma;
                        n_status = ST_OK;
                        n_state  = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_r   = cs_next;
                n_q   = q_div;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_BITS - 1)) begin
                    // only the most negative dividend over one sets overflow here
                    n_ovf   = q_div[WORD_BITS-1];
                    n_state = (r_digits == 4'd0 || q_div[WORD_BITS-1]) ? S_ROUND : S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (r_step == 3'd0) begin
                    n_r    = m10_out;
                    n_d    = 3'd0;
                    n_step = 3'd1;
                end else if (r_step != 3'd4) begin
                    n_r    = cs_next;
                    n_d    = {r_d[1:0], cs_ge};
                    n_step = r_step + 1'b1;
                end else begin
                    n_r      = cs_next;
                    n_step   = 3'd0;
                    n_digits = r_digits - 1'b1;
                    if (r_q > BIG_LIMIT) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_q   = q_digit;
                        n_ovf = q_digit[WORD_BITS-1];
                    end
                    if (r_digits == 4'd1 || n_ovf) begin
                        n_state = S_ROUND;
                    end
                end
            end
            S_ROUND: begin
                // half up on the last remainder
                if (!r_ovf && cs_ge) begin
                    n_q   = q_inc;
                    n_ovf = q_inc[WORD_BITS-1];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_quot   = res;
                    n_o_status = r_ovf ? ST_OVF : r_status;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_ovf     <= 1'b0;
            r_step    <= 3'd0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_ovf     <= n_ovf;
            r_step    <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q        <= n_q;
        r_r        <= n_r;
        r_mb       <= n_mb;
        r_neg      <= n_neg;
        r_status   <= n_status;
        r_cnt      <= n_cnt;
        r_digits   <= n_digits;
        r_d        <= n_d;
        r_o_quot   <= n_o_quot;
        r_o_status <= n_o_status;
    end

`ifndef ASSERT_OFF
    // remainder below divisor at the start of every digit
    a_digit_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT && r_step == 3'd0) |-> (r_r < r_mb))
        else $error("digit step entered with remainder not below divisor");

    // overflow cannot be set while the integer quotient is being built
    a_div_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !r_ovf)
        else $error("overflow flagged during radix-2 steps");

    // error results carry zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_status == ST_DIV_ZERO || r_o_status == ST_TOO_BIG))
        |-> (r_o_quot == '0))
        else $error("divisor error with non-zero quotient");

    // overflow results are saturated
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == ST_OVF)
        |-> (r_o_quot == MAG_MAX || r_o_quot == (~MAG_MAX + 1'b1)))
        else $error("overflow result not saturated");
`endif

endmodule
